@@ rtl/core/triangle_face_normal_defines.svh @@
// assertion macros used by the queue, clocked on clk and held off during reset
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH

// same-cycle implication
`define TFN_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tfn check failed");

// next-cycle implication
`define TFN_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tfn check failed");

`endif

@@ rtl/core/tfn_pkg.sv @@
package tfn_pkg;

	localparam int COORD_BITS       = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int SCALE_BITS       = 31;

	localparam int EW   = COORD_BITS + 1;
	localparam int PW   = 2 * EW;
	localparam int CXW  = PW + 1;
	localparam int MW   = 2 * COORD_BITS + 1;
	localparam int TW   = $clog2(MW + 1);
	localparam int UW   = SCALE_BITS;
	localparam int SQW  = 2 * SCALE_BITS + 2;
	localparam int RW   = SCALE_BITS + 1;
	localparam int RMW  = RW + 2;
	localparam int NW   = SCALE_BITS + NORMAL_FRAC_BITS + 1;
	localparam int QB   = NORMAL_FRAC_BITS + 1;
	localparam int OW   = NORMAL_FRAC_BITS + 2;
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic nx;
		logic ny;
		logic nz;
		logic degen;
		logic last;
	} tfn_flags_t;

	typedef struct packed {
		logic [UW-1:0] ux;
		logic [UW-1:0] uy;
		logic [UW-1:0] uz;
		tfn_flags_t    fl;
	} tfn_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tfn_qstat_t;

endpackage

@@ rtl/core/triangle_face_normal.sv @@
// channel  valid      stall      payload
// in       in_valid   in_stall   a_x..c_z (q8.8), last_in
// out      out_valid  out_stall  norm_x..norm_z (q1.14), degenerate, last_out
//
// one triangle per clock sustained while out_stall stays low; path is 5 front stages,
// the four-entry queue, then 2 + 32 root stages + 1 + 15 divide stages + output
// register; the root and divide pipes each resolve one bit per stage
// the front stalls only when its last stage holds an item and the queue is full
// the back pipe holds as a whole while out_valid is high and out_stall is set
// arst_n clears all valid flags and the queue pointers
module triangle_face_normal import tfn_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] a_z,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] b_z,
	input  logic signed [COORD_BITS-1:0] c_x,
	input  logic signed [COORD_BITS-1:0] c_y,
	input  logic signed [COORD_BITS-1:0] c_z,
	input  logic                         last_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [OW-1:0]         norm_x,
	output logic signed [OW-1:0]         norm_y,
	output logic signed [OW-1:0]         norm_z,
	output logic                         degenerate,
	output logic                         last_out
);

	tfn_qstat_t qstat;
	tfn_item_t  wr_item, rd_item;
	logic       push, pop;

	tfn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.a_x      (a_x),
		.a_y      (a_y),
		.a_z      (a_z),
		.b_x      (b_x),
		.b_y      (b_y),
		.b_z      (b_z),
		.c_x      (c_x),
		.c_y      (c_y),
		.c_z      (c_z),
		.last_in  (last_in),
		.qstat    (qstat),
		.push     (push),
		.item     (wr_item)
	);

	tfn_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.qstat   (qstat)
	);

	tfn_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (rd_item),
		.qstat      (qstat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.norm_x     (norm_x),
		.norm_y     (norm_y),
		.norm_z     (norm_z),
		.degenerate (degenerate),
		.last_out   (last_out)
	);

endmodule

@@ rtl/core/tfn_front.sv @@
module tfn_front import tfn_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] a_z,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	input  logic signed [COORD_BITS-1:0] b_z,
	input  logic signed [COORD_BITS-1:0] c_x,
	input  logic signed [COORD_BITS-1:0] c_y,
	input  logic signed [COORD_BITS-1:0] c_z,
	input  logic                         last_in,
	input  tfn_qstat_t                   qstat,
	output logic                         push,
	output tfn_item_t                    item
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic last_s1, last_s2, last_s3, last_s4;

	logic signed [EW-1:0] e1x_s1, e1y_s1, e1z_s1, e2x_s1, e2y_s1, e2z_s1;
	logic signed [PW-1:0] pxa_s2, pxb_s2, pya_s2, pyb_s2, pza_s2, pzb_s2;
	logic [MW-1:0] mx_s3, my_s3, mz_s3;
	logic nx_s3, ny_s3, nz_s3;
	logic [MW-1:0] mx_s4, my_s4, mz_s4;
	logic nx_s4, ny_s4, nz_s4;
	logic [TW-1:0] top_s4;
	tfn_item_t item_s5;

	logic signed [CXW-1:0] dx, dy, dz;
	logic [MW-1:0] orv;
	logic [TW-1:0] top;
	logic [MW+UW-1:0] wx, wy, wz;

	assign en       = !(v_s5 && qstat.full);
	assign in_stall = !en;
	assign push     = v_s5 && !qstat.full;
	assign item     = item_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// edges
	always_ff @(posedge clk) begin
		if (en) begin
			e1x_s1  <= EW'(b_x) - EW'(a_x);
			e1y_s1  <= EW'(b_y) - EW'(a_y);
			e1z_s1  <= EW'(b_z) - EW'(a_z);
			e2x_s1  <= EW'(c_x) - EW'(a_x);
			e2y_s1  <= EW'(c_y) - EW'(a_y);
			e2z_s1  <= EW'(c_z) - EW'(a_z);
			last_s1 <= last_in;
		end
	end

	// cross product partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pxa_s2  <= PW'(e1y_s1) * PW'(e2z_s1);
			pxb_s2  <= PW'(e1z_s1) * PW'(e2y_s1);
			pya_s2  <= PW'(e1z_s1) * PW'(e2x_s1);
			pyb_s2  <= PW'(e1x_s1) * PW'(e2z_s1);
			pza_s2  <= PW'(e1x_s1) * PW'(e2y_s1);
			pzb_s2  <= PW'(e1y_s1) * PW'(e2x_s1);
			last_s2 <= last_s1;
		end
	end

	always_comb begin
		dx = CXW'(pxa_s2) - CXW'(pxb_s2);
		dy = CXW'(pya_s2) - CXW'(pyb_s2);
		dz = CXW'(pza_s2) - CXW'(pzb_s2);
	end

	// sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			nx_s3   <= dx[CXW-1];
			ny_s3   <= dy[CXW-1];
			nz_s3   <= dz[CXW-1];
			mx_s3   <= dx[CXW-1] ? MW'(-dx) : MW'(dx);
			my_s3   <= dy[CXW-1] ? MW'(-dy) : MW'(dy);
			mz_s3   <= dz[CXW-1] ? MW'(-dz) : MW'(dz);
			last_s3 <= last_s2;
		end
	end

	// bit length of the largest magnitude
	always_comb begin
		orv = mx_s3 | my_s3 | mz_s3;
		top = '0;
		for (int i = 0; i < MW; i++) begin
			if (orv[i]) top = TW'(i + 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s4   <= mx_s3;
			my_s4   <= my_s3;
			mz_s4   <= mz_s3;
			nx_s4   <= nx_s3;
			ny_s4   <= ny_s3;
			nz_s4   <= nz_s3;
			top_s4  <= top;
			last_s4 <= last_s3;
		end
	end

	// common scale, largest lands in [2^30, 2^31)
	always_comb begin
		wx = {mx_s4, UW'(0)} >> top_s4;
		wy = {my_s4, UW'(0)} >> top_s4;
		wz = {mz_s4, UW'(0)} >> top_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s5.ux       <= wx[UW-1:0];
			item_s5.uy       <= wy[UW-1:0];
			item_s5.uz       <= wz[UW-1:0];
			item_s5.fl.nx    <= nx_s4;
			item_s5.fl.ny    <= ny_s4;
			item_s5.fl.nz    <= nz_s4;
			item_s5.fl.degen <= (top_s4 == '0);
			item_s5.fl.last  <= last_s4;
		end
	end

endmodule

@@ rtl/core/tfn_queue.sv @@
`include "triangle_face_normal_defines.svh"

module tfn_queue import tfn_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tfn_item_t  wr_item,
	input  logic       pop,
	output tfn_item_t  rd_item,
	output tfn_qstat_t qstat
);

	tfn_item_t     mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QAW:0]   count_q;

	assign qstat.full  = (count_q == (QAW+1)'(QDEPTH));
	assign qstat.empty = (count_q == '0);
	assign rd_item     = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop)  rptr_q <= rptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	`TFN_ASSERT_NOW(a_no_push_full, qstat.full, !push || pop)
	`TFN_ASSERT_NEXT(a_count_up, push && !pop, count_q == $past(count_q) + 1'b1)
	`TFN_ASSERT_NEXT(a_count_down, pop && !push, count_q == $past(count_q) - 1'b1)
	`TFN_ASSERT_NOW(a_no_pop_empty, qstat.empty, !pop)

endmodule

@@ rtl/core/tfn_back.sv @@
module tfn_back import tfn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tfn_item_t            head,
	input  tfn_qstat_t           qstat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [OW-1:0] norm_x,
	output logic signed [OW-1:0] norm_y,
	output logic signed [OW-1:0] norm_z,
	output logic                 degenerate,
	output logic                 last_out
);

	logic en;
	logic v_s1, v_s2;
	tfn_item_t it_s1, it_s2;
	logic [2*UW-1:0] sqx_s1, sqy_s1, sqz_s1;
	logic [SQW-1:0] sum_s2;

	// square root stages, index 0 is the sum stage output
	logic [SQW-1:0] sqr_x    [RW+1];
	logic [RMW-1:0] sqr_rem  [RW+1];
	logic [RW-1:0]  sqr_root [RW+1];
	tfn_item_t      sqr_it   [RW+1];
	logic           sqr_v    [RW+1];

	// divide stages, index 0 is the numerator stage
	logic [NW-1:0]  div_rem [QB+1][3];
	logic [QB-1:0]  div_q   [QB+1][3];
	logic [RW-1:0]  div_len [QB+1];
	tfn_flags_t     div_fl  [QB+1];
	logic           div_v   [QB+1];

	logic [UW-1:0]  nu [3];
	logic           fneg [3];
	logic [QB-1:0]  mag [3];
	logic [OW-1:0]  res [3];

	assign en  = !(out_valid && out_stall);
	assign pop = en && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= !qstat.empty;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1  <= head;
			sqx_s1 <= (2*UW)'(head.ux) * (2*UW)'(head.ux);
			sqy_s1 <= (2*UW)'(head.uy) * (2*UW)'(head.uy);
			sqz_s1 <= (2*UW)'(head.uz) * (2*UW)'(head.uz);
			it_s2  <= it_s1;
			sum_s2 <= SQW'(sqx_s1) + SQW'(sqy_s1) + SQW'(sqz_s1);
		end
	end

	assign sqr_x[0]    = sum_s2;
	assign sqr_rem[0]  = '0;
	assign sqr_root[0] = '0;
	assign sqr_it[0]   = it_s2;
	assign sqr_v[0]    = v_s2;

	// one root bit per stage
	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [RMW-1:0] cat, trial;
		logic           ge;

		always_comb begin
			cat   = {sqr_rem[k][RW-1:0], sqr_x[k][SQW-1 -: 2]};
			trial = {sqr_root[k], 2'b01};
			ge    = (cat >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sqr_v[k+1] <= 1'b0;
			else if (en) sqr_v[k+1] <= sqr_v[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sqr_rem[k+1]  <= ge ? (cat - trial) : cat;
				sqr_root[k+1] <= {sqr_root[k][RW-2:0], ge};
				sqr_x[k+1]    <= sqr_x[k] << 2;
				sqr_it[k+1]   <= sqr_it[k];
			end
		end
	end

	always_comb begin
		nu[0] = sqr_it[RW].ux;
		nu[1] = sqr_it[RW].uy;
		nu[2] = sqr_it[RW].uz;
	end

	// rounded numerator u * 2^f + len / 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_v[0] <= 1'b0;
		else if (en) div_v[0] <= sqr_v[RW];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				div_rem[0][c] <= NW'({nu[c], NORMAL_FRAC_BITS'(0)})
					+ NW'(sqr_root[RW] >> 1);
				div_q[0][c]   <= '0;
			end
			div_len[0] <= sqr_root[RW];
			div_fl[0]  <= sqr_it[RW].fl;
		end
	end

	// restoring divide, one quotient bit per stage for all three components
	for (genvar s = 0; s < QB; s++) begin : g_div
		logic [NW-1:0] den;
		logic          ge [3];

		always_comb begin
			den = NW'(div_len[s]) << (QB - 1 - s);
			for (int c = 0; c < 3; c++) ge[c] = (div_rem[s][c] >= den);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_v[s+1] <= 1'b0;
			else if (en) div_v[s+1] <= div_v[s];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < 3; c++) begin
					div_rem[s+1][c] <= ge[c] ? (div_rem[s][c] - den) : div_rem[s][c];
					div_q[s+1][c]   <= {div_q[s][c][QB-2:0], ge[c]};
				end
				div_len[s+1] <= div_len[s];
				div_fl[s+1]  <= div_fl[s];
			end
		end
	end

	// saturate at one, then apply the sign; degenerate items give zero
	always_comb begin
		fneg[0] = div_fl[QB].nx;
		fneg[1] = div_fl[QB].ny;
		fneg[2] = div_fl[QB].nz;
		for (int c = 0; c < 3; c++) begin
			mag[c] = (div_q[QB][c] > QB'(1 << NORMAL_FRAC_BITS))
				? QB'(1 << NORMAL_FRAC_BITS) : div_q[QB][c];
			if (div_fl[QB].degen) res[c] = '0;
			else if (fneg[c])     res[c] = OW'(0) - OW'(mag[c]);
			else                  res[c] = OW'(mag[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= div_v[QB];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			norm_x     <= res[0];
			norm_y     <= res[1];
			norm_z     <= res[2];
			degenerate <= div_fl[QB].degen;
			last_out   <= div_fl[QB].last;
		end
	end

endmodule

@@ tb/triangle_face_normal_test.sv @@
`timescale 1ns / 1ps

module triangle_face_normal_test;
	import tfn_pkg::*;

	typedef struct {
		logic signed [COORD_BITS-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
		logic                         last;
	} triangle_t;

	typedef struct {
		logic signed [OW-1:0] nx, ny, nz;
		logic                 degen;
		logic                 last;
	} normal_t;

	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COORD_BITS-1:0] a_x = '0, a_y = '0, a_z = '0;
	logic signed [COORD_BITS-1:0] b_x = '0, b_y = '0, b_z = '0;
	logic signed [COORD_BITS-1:0] c_x = '0, c_y = '0, c_z = '0;
	logic last_in = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [OW-1:0] norm_x, norm_y, norm_z;
	logic degenerate, last_out;

	triangle_t pending_tris[$];
	normal_t   expected_normals[$];
	triangle_t offered;
	int        cycle_count = 0;
	int        hold_left = 0;
	int        mismatch_count = 0;
	int        normals_seen = 0;
	int        degen_seen = 0;

	triangle_face_normal i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_x(b_x), .b_y(b_y), .b_z(b_z),
		.c_x(c_x), .c_y(c_y), .c_z(c_z),
		.last_in(last_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.degenerate(degenerate), .last_out(last_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit [63:0] int_sqrt(bit [63:0] x);
		bit [63:0] root, bitpos;
		root = 0;
		bitpos = 64'd1 << 62;
		while (bitpos > x)
			bitpos >>= 2;
		while (bitpos != 0) begin
			if (x >= root + bitpos) begin
				x -= root + bitpos;
				root = (root >> 1) + bitpos;
			end else begin
				root >>= 1;
			end
			bitpos >>= 2;
		end
		return root;
	endfunction

	function automatic normal_t face_normal(triangle_t t);
		longint    e1x, e1y, e1z, e2x, e2y, e2z;
		longint    crs[3];
		bit [63:0] mag[3];
		bit [63:0] u[3];
		bit [63:0] len, q;
		int        top, bl;
		logic signed [OW-1:0] comp[3];
		normal_t   r;
		e1x = longint'(t.bx) - longint'(t.ax);
		e1y = longint'(t.by) - longint'(t.ay);
		e1z = longint'(t.bz) - longint'(t.az);
		e2x = longint'(t.cx) - longint'(t.ax);
		e2y = longint'(t.cy) - longint'(t.ay);
		e2z = longint'(t.cz) - longint'(t.az);
		crs[0] = e1y * e2z - e1z * e2y;
		crs[1] = e1z * e2x - e1x * e2z;
		crs[2] = e1x * e2y - e1y * e2x;
		top = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = crs[i] < 0 ? 64'(-crs[i]) : 64'(crs[i]);
			bl = 0;
			for (int k = 0; k < 64; k++)
				if (mag[i][k]) bl = k + 1;
			if (bl > top) top = bl;
		end
		r.last = t.last;
		if (top == 0) begin
			r.nx = '0; r.ny = '0; r.nz = '0;
			r.degen = 1'b1;
			return r;
		end
		// common scale puts the largest magnitude in [2^30, 2^31)
		for (int i = 0; i < 3; i++)
			u[i] = top > SCALE_BITS ? mag[i] >> (top - SCALE_BITS)
				: mag[i] << (SCALE_BITS - top);
		len = int_sqrt(u[0] * u[0] + u[1] * u[1] + u[2] * u[2]);
		if (len == 0) len = 1;
		for (int i = 0; i < 3; i++) begin
			q = ((u[i] << NORMAL_FRAC_BITS) + (len >> 1)) / len;
			if (q > (64'd1 << NORMAL_FRAC_BITS)) q = 64'd1 << NORMAL_FRAC_BITS;
			if (crs[i] < 0) q = -q;
			comp[i] = q[OW-1:0];
		end
		r.nx = comp[0]; r.ny = comp[1]; r.nz = comp[2];
		r.degen = 1'b0;
		return r;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] pick_coord(int mode);
		case (mode)
			0: return COORD_BITS'($urandom);
			1: return COORD_BITS'(int'($urandom_range(0, 1024)) - 512);
			default: return COORD_BITS'(int'($urandom_range(0, 16)) - 8);
		endcase
	endfunction

	task automatic queue_tri(int ax, ay, az, bx, by, bz, cx, cy, cz, bit last);
		triangle_t t;
		t.ax = COORD_BITS'(ax); t.ay = COORD_BITS'(ay); t.az = COORD_BITS'(az);
		t.bx = COORD_BITS'(bx); t.by = COORD_BITS'(by); t.bz = COORD_BITS'(bz);
		t.cx = COORD_BITS'(cx); t.cy = COORD_BITS'(cy); t.cz = COORD_BITS'(cz);
		t.last = last;
		pending_tris.push_back(t);
	endtask

	function automatic bit sender_idles();
		if (cycle_count > 300 && cycle_count < 900) return 1'b0;
		return $urandom_range(0, 99) < 32;
	endfunction

	// driver: next triangle goes out once the current one has transferred
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				expected_normals.push_back(face_normal(offered));
			if (!in_valid || !in_stall) begin
				if (pending_tris.size() != 0 && !sender_idles()) begin
					offered = pending_tris.pop_front();
					in_valid <= 1'b1;
					a_x <= offered.ax; a_y <= offered.ay; a_z <= offered.az;
					b_x <= offered.bx; b_y <= offered.by; b_z <= offered.bz;
					c_x <= offered.cx; c_y <= offered.cy; c_z <= offered.cz;
					last_in <= offered.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		normal_t exp_n;
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				normals_seen++;
				if (degenerate) degen_seen++;
				if (expected_normals.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected normal %0d %0d %0d at cycle %0d",
							norm_x, norm_y, norm_z, cycle_count);
				end else begin
					exp_n = expected_normals.pop_front();
					if (norm_x !== exp_n.nx || norm_y !== exp_n.ny || norm_z !== exp_n.nz ||
						degenerate !== exp_n.degen || last_out !== exp_n.last) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: exp %0d %0d %0d d%0b l%0b got %0d %0d %0d d%0b l%0b",
								exp_n.nx, exp_n.ny, exp_n.nz, exp_n.degen, exp_n.last,
								norm_x, norm_y, norm_z, degenerate, last_out);
					end
				end
			end
		end
	end

	// receiver stall, with one long hold-off to back the block up
	always @(posedge clk) begin
		if (arst_n) begin
			if (cycle_count == 1500) hold_left = 400;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (cycle_count > 300 && cycle_count < 900) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= $urandom_range(0, 99) < 32;
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		int mode, dx, dy, dz;
		triangle_t t;
		// directed: degenerate, axis planes, extremes, saturation corners
		queue_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		queue_tri(5, 5, 5, 5, 5, 5, 9, 1, 3, 1);
		queue_tri(0, 0, 0, 256, 256, 256, 512, 512, 512, 0);
		queue_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 0);
		queue_tri(0, 0, 0, 0, 256, 0, 256, 0, 0, 1);
		queue_tri(0, 0, 0, 0, 0, 256, 256, 0, 0, 0);
		queue_tri(0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
		queue_tri(-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768, 0);
		queue_tri(32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767, 1);
		queue_tri(-32768, -32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, 0);
		queue_tri(-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768, 0);
		queue_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 0);
		queue_tri(0, 0, 0, 1, 1, 1, 1, -1, 0, 1);
		queue_tri(0, 0, 0, 1, 2, 3, 2, 4, 7, 0);
		queue_tri(100, -200, 300, 101, -200, 300, 100, -199, 301, 0);
		queue_tri(0, 0, 0, 32767, 1, 0, 1, 32767, 0, 0);
		queue_tri(-1, -1, -1, 1, 1, 1, 1, 1, -1, 1);
		queue_tri(0, 0, 0, 3, 4, 0, 4, -3, 0, 0);
		queue_tri(0, 0, 0, 1, 1, 0, 1, 0, 1, 0);
		queue_tri(0, 0, 0, -32768, 0, 0, 0, 0, -32768, 1);
		for (int i = 0; i < 1580; i++) begin
			mode = $urandom_range(0, 9);
			if (mode < 2) begin
				// collinear or repeated vertices
				t.ax = pick_coord(1); t.ay = pick_coord(1); t.az = pick_coord(1);
				dx = $urandom_range(0, 200) - 100;
				dy = $urandom_range(0, 200) - 100;
				dz = $urandom_range(0, 200) - 100;
				if (mode == 0) begin
					dx = 0; dy = 0; dz = 0;
				end
				t.bx = COORD_BITS'(t.ax + dx);
				t.by = COORD_BITS'(t.ay + dy);
				t.bz = COORD_BITS'(t.az + dz);
				t.cx = COORD_BITS'(t.ax - 2 * dx);
				t.cy = COORD_BITS'(t.ay - 2 * dy);
				t.cz = COORD_BITS'(t.az - 2 * dz);
			end else begin
				mode = mode < 6 ? 0 : (mode < 9 ? 1 : 2);
				t.ax = pick_coord(mode); t.ay = pick_coord(mode); t.az = pick_coord(mode);
				t.bx = pick_coord(mode); t.by = pick_coord(mode); t.bz = pick_coord(mode);
				t.cx = pick_coord(mode); t.cy = pick_coord(mode); t.cz = pick_coord(mode);
			end
			t.last = 1'($urandom_range(0, 1));
			pending_tris.push_back(t);
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_tris.size() != 0 || in_valid || expected_normals.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d face normals, %0d of them degenerate, over %0d cycles",
			normals_seen, degen_seen, cycle_count);
		$display("stimulus: corner and axis triangles, collinear sets, full-range and small meshes");
		if (mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
